// File: src/qpo_pkg.sv
`default_nettype none

package qpo_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int AMP_BITS        = 16;
    localparam int TABLE_ADDR_BITS = 10;

    localparam int STEP_BITS = 32;
    localparam int GAIN_BITS = 16;
    localparam int PROD_BITS = STEP_BITS + GAIN_BITS;
    // product is in units of 2^-40 turn
    localparam int PROD_FRAC = 40;

    localparam int TAB_N     = 1 << TABLE_ADDR_BITS;
    localparam int ROM_ADDR_BITS = TABLE_ADDR_BITS + 1;

    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int ROUND_SH = 30 - (AMP_BITS - 1);
    localparam longint unsigned TAYLOR_DIV [0:9] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef logic [AMP_BITS-1:0] qtab_t [0:TAB_N];

    typedef struct packed {
        logic [ROM_ADDR_BITS-1:0] addr_sin;
        logic [ROM_ADDR_BITS-1:0] addr_cos;
    } rom_req_t;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
        logic                  empty;
    } fifo_stat_t;

    // quarter-wave table, taylor series in q30 with integer arithmetic
    function automatic qtab_t build_qtab();
        qtab_t t;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint s;
        longint v;
        longint top;
        top = (longint'(1) <<< (AMP_BITS - 1)) - 1;
        for (int k = 0; k <= TAB_N; k++)
        begin
            x    = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
            x2   = (x * x) >> 30;
            term = x;
            s    = longint'(x);
            for (int n = 1; n <= 10; n++)
            begin
                term = (term * x2) >> 30;
                term = term / TAYLOR_DIV[n-1];
                if ((n % 2) == 1)
                    s = s - longint'(term);
                else
                    s = s + longint'(term);
            end
            if (s < 0)
                s = 0;
            v = (s + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
            if (v > top)
                v = top;
            t[k] = AMP_BITS'(v);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// File: src/quadrature_phase_oscillator.sv
// quadrature oscillator: one signed phase step in, one cosine/sine pair out
// s_axis carries the step (tdata[31:0], signed, 2^-32 turn units)
// m_axis carries the pair (tdata[15:0] cosine, tdata[31:16] sine, q1.15)
// the pair is taken at the phase before the step; the phase then moves by
// step * gain, gain written on cfg_wr_en / cfg_wr_data as signed q8.8
// throughput: one transaction per cycle while s_axis_tready is high;
// the stages are multiply, phase read-modify-write on the phase memory
// with forwarding, table address, registered table read, and the sign
// fix into an eight-entry output queue
// s_axis_tready follows a credit count: queued plus in-flight results may
// not pass eight, so input keeps flowing while a result waits on m_axis
// and stops once queued and in-flight results together reach eight
// reset: phase and gain go to zero, the queue empties, nothing in flight
`default_nettype none

module quadrature_phase_oscillator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // step
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // cosine, sine
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data     // gain
);

    localparam int PB    = qpo_pkg::PHASE_BITS;
    localparam int TA    = qpo_pkg::TABLE_ADDR_BITS;
    localparam int AW    = qpo_pkg::ROM_ADDR_BITS;
    localparam int AMP   = qpo_pkg::AMP_BITS;
    localparam int SH_R  = (PB < qpo_pkg::PROD_FRAC) ? (qpo_pkg::PROD_FRAC - PB) : 0;
    localparam int SH_L  = (PB > qpo_pkg::PROD_FRAC) ? (PB - qpo_pkg::PROD_FRAC) : 0;
    localparam int EXT_W = qpo_pkg::PROD_BITS + SH_L;
    localparam logic [AW-1:0] TAB_TOP = AW'(qpo_pkg::TAB_N);

    logic signed [qpo_pkg::GAIN_BITS-1:0] gain_reg;
    logic                                 in_acc;

    logic signed [qpo_pkg::PROD_BITS-1:0] prod_reg;
    logic signed [qpo_pkg::PROD_BITS-1:0] prod_next;
    logic                                 va_reg;

    logic signed [EXT_W-1:0]              prod_ext;
    logic signed [EXT_W-1:0]              prod_aln;
    logic [PB-1:0]                        inc;
    logic [PB-1:0]                        phase_cur;
    logic [PB-1:0]                        ph_reg;
    logic                                 vb_reg;

    logic [TA+1:0]                        ph_top;
    logic [1:0]                           quad_s;
    logic [1:0]                           quad_c;
    logic [TA-1:0]                        idx;
    qpo_pkg::rom_req_t                    req_next;
    qpo_pkg::rom_req_t                    req_reg;
    logic                                 neg_s_c_reg;
    logic                                 neg_c_c_reg;
    logic                                 vc_reg;

    logic [AMP-1:0]                       sin_mag;
    logic [AMP-1:0]                       cos_mag;
    logic                                 neg_s_d_reg;
    logic                                 neg_c_d_reg;
    logic                                 vd_reg;

    logic [AMP-1:0]                       sine_val;
    logic [AMP-1:0]                       cosine_val;
    qpo_pkg::fifo_stat_t                  fstat;
    logic [qpo_pkg::FIFO_CNT_W-1:0]       occupancy;

    // credits: queued plus in-flight results
    assign occupancy = fstat.count
                     + qpo_pkg::FIFO_CNT_W'(va_reg) + qpo_pkg::FIFO_CNT_W'(vb_reg)
                     + qpo_pkg::FIFO_CNT_W'(vc_reg) + qpo_pkg::FIFO_CNT_W'(vd_reg);
    assign s_axis_tready = (occupancy < qpo_pkg::FIFO_CNT_W'(qpo_pkg::FIFO_DEPTH));
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign prod_next = $signed(s_axis_tdata) * gain_reg;

    // align product to phase units, arithmetic shift floors
    assign prod_ext = EXT_W'(prod_reg);
    assign prod_aln = (prod_ext <<< SH_L) >>> SH_R;
    assign inc      = prod_aln[PB-1:0];

    qpo_phase_ram u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (va_reg),
        .inc       (inc),
        .phase_cur (phase_cur)
    );

    // quadrant and mirrored index; cosine is a quarter turn ahead
    always_comb
    begin
        ph_top = ph_reg[PB-1 -: TA+2];
        quad_s = ph_top[TA+1:TA];
        quad_c = quad_s + 2'd1;
        idx    = ph_top[TA-1:0];
        req_next.addr_sin = quad_s[0] ? (TAB_TOP - AW'(idx)) : AW'(idx);
        req_next.addr_cos = quad_c[0] ? (TAB_TOP - AW'(idx)) : AW'(idx);
    end

    qpo_sin_rom u_rom (
        .clk     (clk),
        .req     (req_reg),
        .sin_mag (sin_mag),
        .cos_mag (cos_mag)
    );

    assign sine_val   = neg_s_d_reg ? (AMP'(0) - sin_mag) : sin_mag;
    assign cosine_val = neg_c_d_reg ? (AMP'(0) - cos_mag) : cos_mag;

    qpo_out_fifo u_fifo (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (vd_reg),
        .push_data     ({sine_val, cosine_val}),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .stat          (fstat)
    );

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        ph_reg      <= phase_cur;
        req_reg     <= req_next;
        neg_s_c_reg <= quad_s[1];
        neg_c_c_reg <= quad_c[1];
        neg_s_d_reg <= neg_s_c_reg;
        neg_c_d_reg <= neg_c_c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vd_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                gain_reg <= $signed(cfg_wr_data);
            va_reg <= in_acc;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(vd_reg && !m_axis_tready
          && (fstat.count == qpo_pkg::FIFO_CNT_W'(qpo_pkg::FIFO_DEPTH))))
        else $error("output queue overflow");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= qpo_pkg::FIFO_CNT_W'(qpo_pkg::FIFO_DEPTH))
        else $error("credit count exceeds queue depth");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        fstat.empty |-> !m_axis_tvalid)
        else $error("result offered from an empty queue");
`endif

endmodule

`default_nettype wire

// File: src/qpo_phase_ram.sv
`default_nettype none

module qpo_phase_ram (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            upd,
    input  wire logic [qpo_pkg::PHASE_BITS-1:0]  inc,
    output logic      [qpo_pkg::PHASE_BITS-1:0]  phase_cur
);

    logic [qpo_pkg::PHASE_BITS-1:0] phase_mem [0:0];
    logic [qpo_pkg::PHASE_BITS-1:0] rdata_reg;
    logic [qpo_pkg::PHASE_BITS-1:0] fwd_data_reg;
    logic                           fwd_reg;
    logic                           init_reg;
    logic [qpo_pkg::PHASE_BITS-1:0] wdata;

    // the read registered at a write edge holds the old value, so forward
    always_comb
    begin
        if (fwd_reg)
            phase_cur = fwd_data_reg;
        else if (init_reg)
            phase_cur = rdata_reg;
        else
            phase_cur = '0;
    end

    assign wdata = phase_cur + inc;

    always_ff @(posedge clk)
    begin
        rdata_reg <= phase_mem[0];
        if (upd)
        begin
            phase_mem[0] <= wdata;
            fwd_data_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg  <= 1'b0;
            init_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= upd;
            if (upd)
                init_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: src/qpo_sin_rom.sv
`default_nettype none

module qpo_sin_rom (
    input  wire logic                          clk,
    input  wire qpo_pkg::rom_req_t             req,
    output logic      [qpo_pkg::AMP_BITS-1:0]  sin_mag,
    output logic      [qpo_pkg::AMP_BITS-1:0]  cos_mag
);

    localparam qpo_pkg::qtab_t SIN_TAB = qpo_pkg::build_qtab();

    logic [qpo_pkg::AMP_BITS-1:0] sin_mag_reg;
    logic [qpo_pkg::AMP_BITS-1:0] cos_mag_reg;

    always_ff @(posedge clk)
    begin
        sin_mag_reg <= SIN_TAB[req.addr_sin];
        cos_mag_reg <= SIN_TAB[req.addr_cos];
    end

    assign sin_mag = sin_mag_reg;
    assign cos_mag = cos_mag_reg;

endmodule

`default_nettype wire

// File: src/qpo_out_fifo.sv
`default_nettype none

module qpo_out_fifo (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    input  wire logic [2*qpo_pkg::AMP_BITS-1:0]    push_data,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [2*qpo_pkg::AMP_BITS-1:0]    m_axis_tdata,
    output qpo_pkg::fifo_stat_t                    stat
);

    logic [2*qpo_pkg::AMP_BITS-1:0]   fifo_mem [0:qpo_pkg::FIFO_DEPTH-1];
    logic [qpo_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [qpo_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [qpo_pkg::FIFO_CNT_W-1:0]   count_reg;
    logic [qpo_pkg::FIFO_CNT_W-1:0]   count_next;
    logic                             pop;

    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = fifo_mem[rd_ptr_reg];
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire
